/* sv/wav_header_stream_parser_unit_macros.svh */
// Assertion macros for the WAV header stream parser.
// Included by the top level; depends on nothing else.
`ifndef WAV_HEADER_STREAM_PARSER_UNIT_MACROS_SVH
`define WAV_HEADER_STREAM_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define WAVHP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define WAVHP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/wavhp_pkg.sv */
// Types and constants for the WAV header stream parser.
// No dependencies; the parser modules and the testbench import this package.
package wavhp_pkg;

	localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
	localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
	localparam logic [31:0] TAG_FMT = 32'h666D_7420;
	localparam logic [31:0] TAG_DATA = 32'h6461_7461;
	localparam logic [31:0] FMT_MIN_LEN = 32'd16;

	localparam logic [3:0] ST_PARSING = 4'd0;
	localparam logic [3:0] ST_DATA_FOUND = 4'd1;
	localparam logic [3:0] ST_PAYLOAD = 4'd2;
	localparam logic [3:0] ST_PAYLOAD_LAST = 4'd3;
	localparam logic [3:0] ST_TRAILING = 4'd4;
	localparam logic [3:0] ST_BAD_RIFF = 4'd5;
	localparam logic [3:0] ST_BAD_FORMAT = 4'd6;
	localparam logic [3:0] ST_TRUNCATED = 4'd7;
	localparam logic [3:0] ST_DATA_BEFORE_FMT = 4'd8;

	typedef enum logic [3:0] {
		PH_RIFF_ID = 4'd0,
		PH_RIFF_LEN = 4'd1,
		PH_WAVE_ID = 4'd2,
		PH_CHUNK_ID = 4'd3,
		PH_CHUNK_LEN = 4'd4,
		PH_FMT_BODY = 4'd5,
		PH_SKIP = 4'd6,
		PH_PAYLOAD = 4'd7,
		PH_TRAILING = 4'd8,
		PH_ERR_RIFF = 4'd9,
		PH_ERR_FMT = 4'd10,
		PH_ERR_TRUNC = 4'd11,
		PH_ERR_ORDER = 4'd12
	} phase_t;

	typedef struct packed {
		phase_t phase;
		logic [3:0] fpos;
		logic [31:0] tag;
		logic [31:0] len;
		logic [31:0] skip;
		logic fmt_seen;
		logic [15:0] fmt_tag;
		logic [15:0] bits;
		logic [1:0] chans;
		logic [31:0] rate;
		logic [31:0] pay_rem;
		logic [31:0] pay_tot;
	} parse_state_t;

	localparam parse_state_t STATE_RESET = '{
		phase: PH_RIFF_ID,
		fpos: 4'd0,
		tag: 32'd0,
		len: 32'd0,
		skip: 32'd0,
		fmt_seen: 1'b0,
		fmt_tag: 16'd0,
		bits: 16'd0,
		chans: 2'd0,
		rate: 32'd0,
		pay_rem: 32'd0,
		pay_tot: 32'd0
	};

	typedef struct packed {
		logic [7:0] data_byte;
		logic first_byte;
		logic last_byte;
	} in_item_t;

	typedef struct packed {
		logic [3:0] status;
		logic [7:0] payload_byte;
		logic [1:0] num_channels;
		logic [31:0] sample_rate;
		logic wide_samples;
		logic [31:0] data_length;
	} result_t;

endpackage

/* sv/wavhp_if.sv */
// Valid/ready channel interfaces for file bytes in and parse results out.
// Depends on nothing; used by the input stage and the top level.
interface wavhp_byte_if;
	logic valid;
	logic ready;
	logic [7:0] data_byte;
	logic first_byte;
	logic last_byte;

	modport source(output valid, data_byte, first_byte, last_byte, input ready);
	modport sink(input valid, data_byte, first_byte, last_byte, output ready);
endinterface

interface wavhp_result_if;
	logic valid;
	logic ready;
	logic [3:0] status;
	logic [7:0] payload_byte;
	logic [1:0] num_channels;
	logic [31:0] sample_rate;
	logic wide_samples;
	logic [31:0] data_length;

	modport source(output valid, status, payload_byte, num_channels, sample_rate,
		wide_samples, data_length, input ready);
	modport sink(input valid, status, payload_byte, num_channels, sample_rate,
		wide_samples, data_length, output ready);
endinterface

/* sv/wavhp_in_reg.sv */
// Input register stage: captures one file byte per request.
// Depends on wavhp_pkg and wavhp_byte_if.
module wavhp_in_reg
	import wavhp_pkg::*;
(
	input logic clk,
	input logic arst_n,
	wavhp_byte_if.sink stream,
	input logic advance,
	output logic valid_s1,
	output in_item_t item_s1
);

	logic take;

	assign stream.ready = !valid_s1 || advance;
	assign take = stream.valid && stream.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= '{data_byte: stream.data_byte, first_byte: stream.first_byte,
				last_byte: stream.last_byte};
		end
	end

endmodule

/* sv/wavhp_step.sv */
// Per-byte parse logic: next parser state and the result for one byte.
// Depends on wavhp_pkg.
module wavhp_step
	import wavhp_pkg::*;
(
	input parse_state_t cur,
	input in_item_t item,
	output parse_state_t nxt,
	output result_t res
);

	always_comb begin
		parse_state_t st;
		logic [3:0] fpos_inc;
		logic fdone;
		logic [31:0] tag_sh;
		logic [31:0] len_sh;
		logic [31:0] skip_dec;
		logic [31:0] pay_dec;
		logic [3:0] status;
		logic [7:0] pay;

		// A first byte restarts the parser before the byte itself is parsed.
		st = item.first_byte ? STATE_RESET : cur;
		fpos_inc = st.fpos + 4'd1;
		fdone = (fpos_inc >= 4'd4);
		tag_sh = {st.tag[23:0], item.data_byte};
		len_sh = {item.data_byte, st.len[31:8]};
		skip_dec = st.skip - 32'd1;
		pay_dec = st.pay_rem - 32'd1;
		nxt = st;
		status = ST_PARSING;
		pay = 8'd0;

		unique case (st.phase)
			PH_RIFF_ID, PH_WAVE_ID, PH_CHUNK_ID: begin
				nxt.tag = tag_sh;
				nxt.fpos = fdone ? 4'd0 : fpos_inc;
				if (fdone) begin
					if (st.phase == PH_RIFF_ID) begin
						nxt.phase = (tag_sh == TAG_RIFF) ? PH_RIFF_LEN : PH_ERR_RIFF;
					end else if (st.phase == PH_WAVE_ID) begin
						nxt.phase = (tag_sh == TAG_WAVE) ? PH_CHUNK_ID : PH_ERR_RIFF;
					end else begin
						nxt.phase = PH_CHUNK_LEN;
					end
				end
			end
			PH_RIFF_LEN: begin
				nxt.len = len_sh;
				nxt.fpos = fdone ? 4'd0 : fpos_inc;
				if (fdone) begin
					nxt.phase = (len_sh != 32'd0) ? PH_WAVE_ID : PH_ERR_RIFF;
				end
			end
			PH_CHUNK_LEN: begin
				nxt.len = len_sh;
				nxt.fpos = fdone ? 4'd0 : fpos_inc;
				if (fdone) begin
					if (st.tag == TAG_DATA) begin
						if (!st.fmt_seen) begin
							nxt.phase = PH_ERR_ORDER;
						end else begin
							nxt.pay_tot = len_sh;
							nxt.pay_rem = len_sh;
							status = ST_DATA_FOUND;
							nxt.phase = (len_sh == 32'd0) ? PH_TRAILING : PH_PAYLOAD;
						end
					end else if (st.tag == TAG_FMT && len_sh >= FMT_MIN_LEN
						&& !st.fmt_seen) begin
						nxt.skip = len_sh - FMT_MIN_LEN;
						nxt.phase = PH_FMT_BODY;
					end else begin
						nxt.skip = len_sh;
						nxt.phase = (len_sh == 32'd0) ? PH_CHUNK_ID : PH_SKIP;
					end
				end
			end
			PH_FMT_BODY: begin
				// The channel count is gathered in the low half of the tag register.
				if (st.fpos == 4'd0) begin
					nxt.fmt_tag = {8'd0, item.data_byte};
				end else if (st.fpos == 4'd1) begin
					nxt.fmt_tag = {item.data_byte, st.fmt_tag[7:0]};
				end else if (st.fpos == 4'd2) begin
					nxt.tag = {24'd0, item.data_byte};
				end else if (st.fpos == 4'd3) begin
					nxt.tag = {st.tag[31:16], item.data_byte, st.tag[7:0]};
				end else if (st.fpos <= 4'd7) begin
					nxt.rate = {item.data_byte, st.rate[31:8]};
				end else if (st.fpos == 4'd14) begin
					nxt.bits = {8'd0, item.data_byte};
				end else if (st.fpos == 4'd15) begin
					nxt.bits = {item.data_byte, st.bits[7:0]};
				end
				if (st.fpos == 4'd15) begin
					nxt.fpos = 4'd0;
					if (nxt.fmt_tag != 16'd1 || nxt.tag > 32'd2
						|| (nxt.bits != 16'd8 && nxt.bits != 16'd16)) begin
						nxt.phase = PH_ERR_FMT;
					end else begin
						nxt.chans = nxt.tag[1:0];
						nxt.fmt_seen = 1'b1;
						nxt.phase = (st.skip == 32'd0) ? PH_CHUNK_ID : PH_SKIP;
					end
				end else begin
					nxt.fpos = fpos_inc;
				end
			end
			PH_SKIP: begin
				nxt.skip = skip_dec;
				if (skip_dec == 32'd0) begin
					nxt.phase = PH_CHUNK_ID;
				end
			end
			PH_PAYLOAD: begin
				pay = item.data_byte;
				nxt.pay_rem = pay_dec;
				if (pay_dec == 32'd0 || item.last_byte) begin
					status = ST_PAYLOAD_LAST;
					nxt.phase = PH_TRAILING;
				end else begin
					status = ST_PAYLOAD;
				end
			end
			PH_TRAILING: begin
				status = ST_TRAILING;
			end
			PH_ERR_RIFF, PH_ERR_FMT, PH_ERR_TRUNC, PH_ERR_ORDER: begin
				nxt.phase = st.phase;
			end
			default: begin
				nxt.phase = PH_ERR_TRUNC;
			end
		endcase

		// The file ended before the payload was reached.
		if (item.last_byte && nxt.phase <= PH_SKIP) begin
			nxt.phase = PH_ERR_TRUNC;
		end

		unique case (nxt.phase)
			PH_ERR_RIFF: status = ST_BAD_RIFF;
			PH_ERR_FMT: status = ST_BAD_FORMAT;
			PH_ERR_TRUNC: status = ST_TRUNCATED;
			PH_ERR_ORDER: status = ST_DATA_BEFORE_FMT;
			default: status = status;
		endcase

		res.status = status;
		res.payload_byte = pay;
		res.num_channels = nxt.fmt_seen ? nxt.chans : 2'd0;
		res.sample_rate = nxt.fmt_seen ? nxt.rate : 32'd0;
		res.wide_samples = nxt.fmt_seen && (nxt.bits == 16'd16);
		res.data_length = nxt.pay_tot;
	end

endmodule

/* sv/wav_header_stream_parser_unit.sv */
// WAV header stream parser, one file byte per request in and one result per byte out.
// The input stage registers each byte and the step logic updates the parser state
// while the result lands in an output register. A new byte is taken every clock
// cycle while results drain; each byte passes the input register and then the output
// register on its way to its result, and the rate of one byte per cycle is set by the
// parser state register, which closes its update loop through the step logic. There is
// no clearing pass after reset. Depends on wavhp_pkg, the channel interfaces,
// wavhp_in_reg, wavhp_step and the assertion macro header.
`include "wav_header_stream_parser_unit_macros.svh"

module wav_header_stream_parser_unit
	import wavhp_pkg::*;
(
	input logic clk,
	input logic arst_n,
	wavhp_byte_if.sink stream,
	wavhp_result_if.source report
);

	logic advance;
	logic valid_s1;
	in_item_t item_s1;
	parse_state_t state_q;
	parse_state_t state_nxt;
	result_t res_nxt;
	logic valid_s2;
	result_t res_s2;

	assign advance = !valid_s2 || report.ready;

	wavhp_in_reg u_in_reg (
		.clk(clk),
		.arst_n(arst_n),
		.stream(stream),
		.advance(advance),
		.valid_s1(valid_s1),
		.item_s1(item_s1)
	);

	wavhp_step u_step (
		.cur(state_q),
		.item(item_s1),
		.nxt(state_nxt),
		.res(res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_s2 <= res_nxt;
		end
	end

	assign report.valid = valid_s2;
	assign report.status = res_s2.status;
	assign report.payload_byte = res_s2.payload_byte;
	assign report.num_channels = res_s2.num_channels;
	assign report.sample_rate = res_s2.sample_rate;
	assign report.wide_samples = res_s2.wide_samples;
	assign report.data_length = res_s2.data_length;

	`WAVHP_ASSERT_NOW(a_payload_only_in_payload, clk, arst_n, valid_s2 && !(res_s2.status == ST_PAYLOAD || res_s2.status == ST_PAYLOAD_LAST), res_s2.payload_byte == 8'd0, "payload byte nonzero outside the payload")
	`WAVHP_ASSERT_NOW(a_payload_needs_format, clk, arst_n, state_q.phase == PH_PAYLOAD || state_q.phase == PH_TRAILING, state_q.fmt_seen, "payload reached without an accepted format")
	`WAVHP_ASSERT_NOW(a_status_in_range, clk, arst_n, valid_s2, res_s2.status <= ST_DATA_BEFORE_FMT, "status code out of range")
	`WAVHP_ASSERT_NEXT(a_stalled_byte_held, clk, arst_n, valid_s1 && !advance, valid_s1 && $stable(item_s1) && $stable(state_q), "stalled byte or parser state changed")

endmodule

/* tb/tb.sv */
// Self-checking testbench for the WAV header stream parser: it streams directed and
// random WAV files, well-formed and broken, and checks every result byte by byte.
// Depends on wavhp_pkg, the channel interfaces and wav_header_stream_parser_unit.
module tb;
	import wavhp_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_BYTES = 280;
	localparam int DRAIN_CYCLES = 8;
	localparam logic [31:0] JUNK_TAGS [4] = '{"LIST", "JUNK", "fact", "bext"};

	// Tracks the parser state per file byte and holds the results still to come.
	class wav_parse_tracker;
		phase_t phase;
		logic [3:0] field_pos;
		logic [31:0] tag_sr;
		logic [31:0] len_sr;
		logic [31:0] skip_left;
		logic fmt_seen;
		logic [15:0] fmt_tag;
		logic [15:0] bits;
		logic [1:0] chans;
		logic [31:0] rate;
		logic [31:0] pay_left;
		logic [31:0] pay_total;
		result_t results_due[$];
		int mismatches;
		int checked;
		int status_seen[16];

		function new();
			clear_state();
			mismatches = 0;
			checked = 0;
			foreach (status_seen[i])
				status_seen[i] = 0;
		endfunction

		function void clear_state();
			phase = PH_RIFF_ID;
			field_pos = 4'd0;
			tag_sr = 32'd0;
			len_sr = 32'd0;
			skip_left = 32'd0;
			fmt_seen = 1'b0;
			fmt_tag = 16'd0;
			bits = 16'd0;
			chans = 2'd0;
			rate = 32'd0;
			pay_left = 32'd0;
			pay_total = 32'd0;
		endfunction

		// Counts one byte of a four-byte field; true when the field is complete.
		function bit field_complete();
			field_pos = field_pos + 4'd1;
			if (field_pos >= 4'd4) begin
				field_pos = 4'd0;
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function void enter_skip(logic [31:0] n);
			skip_left = n;
			phase = (n == 32'd0) ? PH_CHUNK_ID : PH_SKIP;
		endfunction

		function result_t parse_byte(in_item_t req);
			logic [3:0] k;
			logic [3:0] status;
			logic [7:0] pay;
			result_t r;
			status = ST_PARSING;
			pay = 8'd0;
			if (req.first_byte)
				clear_state();
			case (phase)
				PH_RIFF_ID, PH_WAVE_ID, PH_CHUNK_ID: begin
					tag_sr = {tag_sr[23:0], req.data_byte};
					if (field_complete()) begin
						if (phase == PH_RIFF_ID)
							phase = (tag_sr == TAG_RIFF) ? PH_RIFF_LEN : PH_ERR_RIFF;
						else if (phase == PH_WAVE_ID)
							phase = (tag_sr == TAG_WAVE) ? PH_CHUNK_ID : PH_ERR_RIFF;
						else
							phase = PH_CHUNK_LEN;
					end
				end
				PH_RIFF_LEN: begin
					len_sr = {req.data_byte, len_sr[31:8]};
					if (field_complete())
						phase = (len_sr != 32'd0) ? PH_WAVE_ID : PH_ERR_RIFF;
				end
				PH_CHUNK_LEN: begin
					len_sr = {req.data_byte, len_sr[31:8]};
					if (field_complete()) begin
						if (tag_sr == TAG_DATA) begin
							if (!fmt_seen) begin
								phase = PH_ERR_ORDER;
							end else begin
								pay_total = len_sr;
								pay_left = len_sr;
								status = ST_DATA_FOUND;
								phase = (len_sr == 32'd0) ? PH_TRAILING : PH_PAYLOAD;
							end
						end else if (tag_sr == TAG_FMT && len_sr >= FMT_MIN_LEN && !fmt_seen) begin
							skip_left = len_sr - FMT_MIN_LEN;
							field_pos = 4'd0;
							phase = PH_FMT_BODY;
						end else begin
							enter_skip(len_sr);
						end
					end
				end
				PH_FMT_BODY: begin
					// Byte offsets within the first 16 bytes of the fmt body.
					k = field_pos;
					case (k)
						4'd0: fmt_tag = {8'd0, req.data_byte};
						4'd1: fmt_tag[15:8] = req.data_byte;
						4'd2: tag_sr = {24'd0, req.data_byte};
						4'd3: tag_sr[15:8] = req.data_byte;
						4'd4, 4'd5, 4'd6, 4'd7: rate = {req.data_byte, rate[31:8]};
						4'd14: bits = {8'd0, req.data_byte};
						4'd15: bits[15:8] = req.data_byte;
						default: ;
					endcase
					if (k == 4'd15) begin
						field_pos = 4'd0;
						if (fmt_tag != 16'd1 || tag_sr > 32'd2 ||
							(bits != 16'd8 && bits != 16'd16)) begin
							phase = PH_ERR_FMT;
						end else begin
							chans = tag_sr[1:0];
							fmt_seen = 1'b1;
							enter_skip(skip_left);
						end
					end else begin
						field_pos = k + 4'd1;
					end
				end
				PH_SKIP: begin
					skip_left = skip_left - 32'd1;
					if (skip_left == 32'd0)
						phase = PH_CHUNK_ID;
				end
				PH_PAYLOAD: begin
					pay = req.data_byte;
					pay_left = pay_left - 32'd1;
					if (pay_left == 32'd0 || req.last_byte) begin
						status = ST_PAYLOAD_LAST;
						phase = PH_TRAILING;
					end else begin
						status = ST_PAYLOAD;
					end
				end
				PH_TRAILING: status = ST_TRAILING;
				PH_ERR_RIFF, PH_ERR_FMT, PH_ERR_TRUNC, PH_ERR_ORDER: ;
				default: phase = PH_ERR_TRUNC;
			endcase
			// The stream ending anywhere before the end of the data chunk header is a truncation.
			if (req.last_byte && phase <= PH_SKIP)
				phase = PH_ERR_TRUNC;
			case (phase)
				PH_ERR_RIFF: status = ST_BAD_RIFF;
				PH_ERR_FMT: status = ST_BAD_FORMAT;
				PH_ERR_TRUNC: status = ST_TRUNCATED;
				PH_ERR_ORDER: status = ST_DATA_BEFORE_FMT;
				default: ;
			endcase
			r.status = status;
			r.payload_byte = pay;
			r.num_channels = fmt_seen ? chans : 2'd0;
			r.sample_rate = fmt_seen ? rate : 32'd0;
			r.wide_samples = fmt_seen && bits == 16'd16;
			r.data_length = pay_total;
			return r;
		endfunction

		function void note_byte(in_item_t req);
			results_due.push_back(parse_byte(req));
		endfunction

		function int pending();
			return results_due.size();
		endfunction

		task report_mismatch(string msg);
			mismatches++;
			if (mismatches <= 40)
				$display("mismatch on result %0d: %s", checked, msg);
		endtask

		task compare_field(string name, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
		endtask

		task check_result(result_t got);
			result_t want;
			if (results_due.size() == 0) begin
				report_mismatch($sformatf("status %0d with no byte outstanding", got.status));
				return;
			end
			want = results_due.pop_front();
			status_seen[want.status]++;
			compare_field("status", 32'(got.status), 32'(want.status));
			compare_field("payload_byte", 32'(got.payload_byte), 32'(want.payload_byte));
			compare_field("num_channels", 32'(got.num_channels), 32'(want.num_channels));
			compare_field("sample_rate", got.sample_rate, want.sample_rate);
			compare_field("wide_samples", 32'(got.wide_samples), 32'(want.wide_samples));
			compare_field("data_length", got.data_length, want.data_length);
			checked++;
		endtask
	endclass

	logic clk;
	logic arst_n;
	int cycles;
	int sent_bytes;
	int files_sent;
	int burst_left;
	bit hold_request;
	in_item_t file_q[$];
	wav_parse_tracker tracker = new();

	wavhp_byte_if stream_if();
	wavhp_result_if result_if();

	wav_header_stream_parser_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.stream(stream_if),
		.report(result_if)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin : watchdog
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles, %0d results outstanding",
					cycles, tracker.pending());
				$display("FAIL");
				$finish;
			end
		end
	end

	function automatic void push_byte(logic [7:0] b);
		in_item_t it;
		it.data_byte = b;
		it.first_byte = 1'b0;
		it.last_byte = 1'b0;
		file_q.push_back(it);
	endfunction

	function automatic void push_random(int n);
		repeat (n) push_byte(8'($urandom));
	endfunction

	// Tags go out first character first, lengths little-endian.
	function automatic void push_tag(logic [31:0] t);
		push_byte(t[31:24]);
		push_byte(t[23:16]);
		push_byte(t[15:8]);
		push_byte(t[7:0]);
	endfunction

	function automatic void push_le16(logic [15:0] v);
		push_byte(v[7:0]);
		push_byte(v[15:8]);
	endfunction

	function automatic void push_le32(logic [31:0] v);
		push_le16(v[15:0]);
		push_le16(v[31:16]);
	endfunction

	function automatic void push_header(logic [31:0] riff_tag, logic [31:0] riff_len,
		logic [31:0] form_tag);
		push_tag(riff_tag);
		push_le32(riff_len);
		push_tag(form_tag);
	endfunction

	function automatic void push_chunk(logic [31:0] tag, logic [31:0] len, int body);
		push_tag(tag);
		push_le32(len);
		push_random(body);
	endfunction

	// A length under 16 gets a body of random bytes instead of format fields.
	function automatic void push_fmt(int len, logic [15:0] ftag, logic [15:0] nchan,
		logic [31:0] srate, logic [15:0] nbits);
		push_tag(TAG_FMT);
		push_le32(len);
		if (len < 16) begin
			push_random(len);
		end else begin
			push_le16(ftag);
			push_le16(nchan);
			push_le32(srate);
			push_le32($urandom);
			push_le16(16'($urandom));
			push_le16(nbits);
			push_random(len - 16);
		end
	endfunction

	function automatic void push_data(logic [31:0] dlen, int pay_cnt, int trail);
		push_tag(TAG_DATA);
		push_le32(dlen);
		push_random(pay_cnt + trail);
	endfunction

	task automatic send_file(input bit mark_first, input bit mark_last);
		in_item_t it;
		int gap;
		if (file_q.size() == 0)
			return;
		if (mark_first)
			file_q[0].first_byte = 1'b1;
		if (mark_last)
			file_q[file_q.size() - 1].last_byte = 1'b1;
		foreach (file_q[i]) begin
			if (burst_left == 0) begin
				gap = $urandom_range(0, 5);
				if (gap > 0) begin
					stream_if.valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
					: $urandom_range(1, 12);
			end
			it = file_q[i];
			stream_if.valid <= 1'b1;
			stream_if.data_byte <= it.data_byte;
			stream_if.first_byte <= it.first_byte;
			stream_if.last_byte <= it.last_byte;
			@(posedge clk);
			while (!stream_if.ready)
				@(posedge clk);
			tracker.note_byte(it);
			burst_left--;
			sent_bytes++;
		end
		file_q.delete();
		files_sent++;
	endtask

	// Lowers valid and waits on the clock before checking, so valid is never lowered and raised in one step.
	task automatic drain_results();
		stream_if.valid <= 1'b0;
		do
			@(posedge clk);
		while (tracker.pending() != 0);
	endtask

	initial begin : receiver
		result_t got;
		int hold_left;
		int stretch_left;
		logic [7:0] stall_pat;
		hold_left = 0;
		stretch_left = 0;
		stall_pat = 8'hFF;
		result_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (result_if.valid && result_if.ready) begin
				got.status = result_if.status;
				got.payload_byte = result_if.payload_byte;
				got.num_channels = result_if.num_channels;
				got.sample_rate = result_if.sample_rate;
				got.wide_samples = result_if.wide_samples;
				got.data_length = result_if.data_length;
				tracker.check_result(got);
			end
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = $urandom_range(200, 300);
			end
			if (hold_left > 0) begin
				hold_left--;
				result_if.ready <= 1'b0;
			end else begin
				if (stretch_left == 0) begin
					stretch_left = $urandom_range(20, 80);
					stall_pat = ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
				end
				stretch_left--;
				result_if.ready <= stall_pat[0];
				stall_pat = {stall_pat[0], stall_pat[7:1]};
			end
		end
	end

	initial begin : stimulus
		int directed_bytes;
		int kind;
		int pay_cnt;
		int trail;
		int cut;
		int idx;
		logic [31:0] dlen;
		logic [31:0] frate;
		logic [15:0] ftag;
		logic [15:0] fchans;
		logic [15:0] fbits;
		arst_n <= 1'b0;
		stream_if.valid <= 1'b0;
		stream_if.data_byte <= 8'd0;
		stream_if.first_byte <= 1'b0;
		stream_if.last_byte <= 1'b0;
		sent_bytes = 0;
		files_sent = 0;
		burst_left = 0;
		hold_request = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Mono 8-bit; the payload runs out on the final byte, which also ends the stream.
		push_header(TAG_RIFF, 32'd44, TAG_WAVE);
		push_fmt(16, 16'd1, 16'd1, 32'd8000, 16'd8);
		push_tag(TAG_DATA);
		push_le32(32'd4);
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(8'h80);
		push_byte(8'h7F);
		send_file(1'b1, 1'b1);
		// More bytes with no new file mark keep trailing.
		push_random(3);
		send_file(1'b0, 1'b0);
		// Stereo 16-bit at the widest rate behind an empty and a short chunk; empty data.
		push_header(TAG_RIFF, 32'hFFFF_FFFF, TAG_WAVE);
		push_chunk(JUNK_TAGS[0], 32'd0, 0);
		push_chunk(JUNK_TAGS[1], 32'd3, 3);
		push_fmt(18, 16'd1, 16'd2, 32'hFFFF_FFFF, 16'd16);
		push_data(32'd0, 0, 3);
		send_file(1'b1, 1'b1);
		// Header errors: wrong RIFF tag, zero RIFF length, wrong form type.
		push_header("RIFX", 32'd36, TAG_WAVE);
		push_random(3);
		send_file(1'b1, 1'b1);
		push_header(TAG_RIFF, 32'd0, TAG_WAVE);
		send_file(1'b1, 1'b1);
		push_header(TAG_RIFF, 32'd36, "WAVF");
		push_random(2);
		send_file(1'b1, 1'b1);
		// Format errors: not PCM, three channels, 24-bit samples.
		push_header(TAG_RIFF, 32'd36, TAG_WAVE);
		push_fmt(16, 16'd3, 16'd1, 32'd44100, 16'd16);
		push_random(2);
		send_file(1'b1, 1'b1);
		push_header(TAG_RIFF, 32'd36, TAG_WAVE);
		push_fmt(16, 16'd1, 16'd3, 32'd44100, 16'd16);
		send_file(1'b1, 1'b1);
		push_header(TAG_RIFF, 32'd36, TAG_WAVE);
		push_fmt(16, 16'd1, 16'd2, 32'd48000, 16'd24);
		send_file(1'b1, 1'b1);
		// Data chunk ahead of any format.
		push_header(TAG_RIFF, 32'd36, TAG_WAVE);
		push_data(32'd4, 4, 0);
		send_file(1'b1, 1'b1);
		// Stream ends inside a huge skipped chunk, inside a fmt body, and on byte one.
		push_header(TAG_RIFF, 32'd36, TAG_WAVE);
		push_chunk(JUNK_TAGS[2], 32'hFFFF_FFF0, 3);
		send_file(1'b1, 1'b1);
		push_header(TAG_RIFF, 32'd36, TAG_WAVE);
		push_tag(TAG_FMT);
		push_le32(32'd16);
		push_random(5);
		send_file(1'b1, 1'b1);
		push_byte(8'h52);
		send_file(1'b1, 1'b1);
		// A short fmt is skipped, zero channels and rate pass, a later fmt is ignored,
		// and a huge data chunk is cut short by the end of the stream.
		push_header(TAG_RIFF, 32'd100, TAG_WAVE);
		push_fmt(12, 16'd0, 16'd0, 32'd0, 16'd0);
		push_fmt(16, 16'd1, 16'd0, 32'd0, 16'd16);
		push_fmt(16, 16'd7, 16'd3, 32'd5, 16'd9);
		push_tag(TAG_DATA);
		push_le32(32'hFFFF_FFFF);
		push_random(6);
		send_file(1'b1, 1'b1);
		directed_bytes = sent_bytes;
		drain_results();

		// The receiver holds off for a long stretch while files keep coming.
		hold_request = 1'b1;
		while (sent_bytes - directed_bytes < RANDOM_BYTES) begin
			kind = $urandom_range(0, 99);
			if (kind >= 94) begin
				// Noise with scattered first and last marks.
				push_random($urandom_range(4, 24));
				foreach (file_q[i]) begin
					file_q[i].first_byte = ($urandom_range(0, 9) == 0);
					file_q[i].last_byte = ($urandom_range(0, 7) == 0);
				end
				send_file(1'b0, 1'b0);
			end else begin
				push_header(TAG_RIFF, ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF
					: $urandom_range(1, 4000), TAG_WAVE);
				ftag = 16'd1;
				fchans = 16'($urandom_range(0, 2));
				fbits = $urandom_range(0, 1) ? 16'd16 : 16'd8;
				case ($urandom_range(0, 4))
					0: frate = 32'd8000;
					1: frate = 32'd44100;
					2: frate = 32'd48000;
					3: frate = $urandom;
					default: frate = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
				endcase
				if (kind >= 65 && kind < 72) begin
					case ($urandom_range(0, 2))
						0: ftag = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(2, 65535));
						1: fchans = 16'($urandom_range(3, 65535));
						default: begin
							fbits = 16'($urandom_range(0, 40));
							if (fbits == 16'd8 || fbits == 16'd16)
								fbits = 16'd24;
						end
					endcase
				end
				case ($urandom_range(0, 9))
					0: begin
						dlen = 32'd0;
						pay_cnt = 0;
					end
					1: begin
						dlen = 32'hFFFF_FF00 | $urandom_range(0, 255);
						pay_cnt = $urandom_range(1, 8);
					end
					default: begin
						dlen = $urandom_range(1, 12);
						pay_cnt = ($urandom_range(0, 4) == 0) ? $urandom_range(1, dlen) : dlen;
					end
				endcase
				trail = (pay_cnt == dlen) ? $urandom_range(0, 3) : 0;
				repeat ($urandom_range(0, 2))
					push_chunk(JUNK_TAGS[$urandom_range(0, 3)], $urandom_range(0, 6), -1);
				if (kind >= 72 && kind < 77) begin
					push_data(dlen, pay_cnt, trail);
					push_fmt(16, ftag, fchans, frate, fbits);
				end else begin
					if ($urandom_range(0, 7) == 0)
						push_fmt($urandom_range(0, 15), 16'd1, 16'd1, 32'd0, 16'd8);
					push_fmt($urandom_range(16, 20), ftag, fchans, frate, fbits);
					if ($urandom_range(0, 3) == 0)
						push_chunk(JUNK_TAGS[$urandom_range(0, 3)], 32'd2, 2);
					if ($urandom_range(0, 7) == 0)
						push_fmt(16, 16'($urandom), 16'($urandom), $urandom, 16'($urandom));
					push_data(dlen, pay_cnt, trail);
				end
				if (kind >= 77 && kind < 87) begin
					idx = $urandom_range(0, (file_q.size() > 48) ? 47 : file_q.size() - 1);
					file_q[idx].data_byte = file_q[idx].data_byte ^ (8'd1 << $urandom_range(0, 7));
				end else if (kind >= 87 && kind < 94) begin
					cut = $urandom_range(1, file_q.size() - 1);
					file_q = file_q[0:cut - 1];
				end
				send_file(1'b1, 1'b1);
			end
			if ($urandom_range(0, 9) == 0)
				drain_results();
		end
		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Streamed %0d files in %0d bytes (%0d random); saw %0d data chunks found,",
			files_sent, sent_bytes, sent_bytes - directed_bytes, tracker.status_seen[ST_DATA_FOUND]);
		$display("%0d payload, %0d last payload, %0d trailing, and %0d/%0d/%0d/%0d error bytes.",
			tracker.status_seen[ST_PAYLOAD], tracker.status_seen[ST_PAYLOAD_LAST],
			tracker.status_seen[ST_TRAILING], tracker.status_seen[ST_BAD_RIFF],
			tracker.status_seen[ST_BAD_FORMAT], tracker.status_seen[ST_TRUNCATED],
			tracker.status_seen[ST_DATA_BEFORE_FMT]);
		if (tracker.mismatches == 0 && tracker.pending() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

/* filelist.f */
+incdir+sv
sv/wavhp_pkg.sv
sv/wavhp_if.sv
sv/wavhp_in_reg.sv
sv/wavhp_step.sv
sv/wav_header_stream_parser_unit.sv
tb/tb.sv
